### rtl/publish_packet_parser_top_defines.svh
// Assertion macros for the publish packet parser.
`ifndef PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH
`define PUBLISH_PACKET_PARSER_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define PPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/ppp_pkg.sv
`default_nettype none

package ppp_pkg;

  localparam int DEF_MAX_LEN_DIGITS = 4;

  localparam logic [27:0] PAYLOAD_MAX = 28'hFFF_FFFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_REMLEN  = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_PID     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SKIP    = 3'd6
  } phase_e;

  // byte_kind codes
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_REMLEN  = 3'd1;
  localparam logic [2:0] KIND_TLEN    = 3'd2;
  localparam logic [2:0] KIND_TOPIC   = 3'd3;
  localparam logic [2:0] KIND_PID     = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_SKIP    = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NO_TLEN   = 3'd2;
  localparam logic [2:0] ST_OVERRUN   = 3'd3;
  localparam logic [2:0] ST_NO_PID    = 3'd4;
  localparam logic [2:0] ST_MALFORMED = 3'd5;

  // ack codes
  localparam logic [1:0] ACK_NONE   = 2'd0;
  localparam logic [1:0] ACK_PUBACK = 2'd1;
  localparam logic [1:0] ACK_PUBREC = 2'd2;

  // QoS values that select an ack
  localparam logic [1:0] QOS_1 = 2'd1;
  localparam logic [1:0] QOS_2 = 2'd2;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  digit_count;
    logic [15:0] tlen_reg;
    logic [15:0] topic_left;
    logic [15:0] ident;
    logic [3:0]  flags;
    logic [27:0] payload_count;
    logic [2:0]  error_code;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_value;
    logic        packet_done;
    logic [2:0]  status;
    logic [1:0]  qos_level;
    logic        dup_flag;
    logic        retain_flag;
    logic [15:0] packet_ident;
    logic [15:0] topic_size;
    logic [27:0] payload_total;
    logic [1:0]  ack_kind;
    logic        retain_action;
  } result_t;

endpackage

`default_nettype wire

### rtl/ppp_core.sv
`default_nettype none

module ppp_core
  import ppp_pkg::*;
#(
  parameter int MAX_LEN_DIGITS = DEF_MAX_LEN_DIGITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_packet_i,
  output result_t         res_o
);

  localparam logic [2:0] MaxDigits = 3'(MAX_LEN_DIGITS);

  parse_state_t st_q, st_upd, st_d;
  logic [2:0]   kind;
  logic [2:0]   status;
  logic [1:0]   qos_q;
  logic [1:0]   qos_upd;
  phase_e       after_topic;
  logic [15:0]  tlen_full;

  assign qos_q       = st_q.flags[2:1];
  assign after_topic = (qos_q != 2'd0) ? PH_PID : PH_PAYLOAD;
  assign tlen_full   = {st_q.tlen_reg[15:8], data_byte_i};

  always_comb begin
    st_upd = st_q;
    kind   = KIND_HEADER;
    unique case (st_q.phase)
      PH_REMLEN: begin
        kind = KIND_REMLEN;
        st_upd.digit_count = st_q.digit_count + 3'd1;
        if (data_byte_i[7]) begin
          if (st_upd.digit_count >= MaxDigits) begin
            st_upd.error_code = ST_MALFORMED;
            st_upd.phase      = PH_SKIP;
          end
        end else begin
          st_upd.digit_count = 3'd0;
          st_upd.phase       = PH_TLEN;
        end
      end
      PH_TLEN: begin
        kind = KIND_TLEN;
        if (st_q.digit_count == 3'd0) begin
          st_upd.tlen_reg    = {data_byte_i, 8'h00};
          st_upd.digit_count = 3'd1;
        end else begin
          st_upd.tlen_reg   = tlen_full;
          st_upd.topic_left = tlen_full;
          if (tlen_full != 16'd0) begin
            st_upd.phase = PH_TOPIC;
          end else begin
            st_upd.digit_count = 3'd0;
            st_upd.phase       = after_topic;
          end
        end
      end
      PH_TOPIC: begin
        kind = KIND_TOPIC;
        st_upd.topic_left = st_q.topic_left - 16'd1;
        if (st_upd.topic_left == 16'd0) begin
          st_upd.digit_count = 3'd0;
          st_upd.phase       = after_topic;
        end
      end
      PH_PID: begin
        kind = KIND_PID;
        if (st_q.digit_count == 3'd0) begin
          st_upd.ident       = {data_byte_i, 8'h00};
          st_upd.digit_count = 3'd1;
        end else begin
          st_upd.ident       = {st_q.ident[15:8], data_byte_i};
          st_upd.digit_count = 3'd0;
          st_upd.phase       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        kind = KIND_PAYLOAD;
        if (st_q.payload_count != PAYLOAD_MAX) begin
          st_upd.payload_count = st_q.payload_count + 28'd1;
        end
      end
      PH_SKIP: begin
        kind = KIND_SKIP;
      end
      default: begin
        // header byte (unused phase code counts as idle)
        kind   = KIND_HEADER;
        st_upd = '0;
        st_upd.flags = data_byte_i[3:0];
        st_upd.phase = PH_REMLEN;
      end
    endcase
  end

  assign qos_upd = st_upd.flags[2:1];

  always_comb begin
    status = st_upd.error_code;
    if (end_of_packet_i) begin
      if (kind == KIND_HEADER) begin
        status = ST_SHORT;
      end else begin
        case (st_upd.phase) inside
          PH_REMLEN, PH_TLEN: status = ST_NO_TLEN;
          PH_TOPIC:           status = ST_OVERRUN;
          PH_PID:             status = ST_NO_PID;
          PH_PAYLOAD:         status = ST_OK;
          default:            status = st_upd.error_code;
        endcase
      end
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.byte_kind     = kind;
    res_o.byte_value    = data_byte_i;
    res_o.packet_done   = end_of_packet_i;
    res_o.status        = status;
    res_o.qos_level     = qos_upd;
    res_o.dup_flag      = st_upd.flags[3];
    res_o.retain_flag   = st_upd.flags[0];
    res_o.packet_ident  = st_upd.ident;
    res_o.topic_size    = st_upd.tlen_reg;
    res_o.payload_total = st_upd.payload_count;
    res_o.ack_kind      = ACK_NONE;
    res_o.retain_action = 1'b0;
    if (end_of_packet_i && (status == ST_OK)) begin
      if (qos_upd == QOS_1) begin
        res_o.ack_kind = ACK_PUBACK;
      end else if (qos_upd == QOS_2) begin
        res_o.ack_kind = ACK_PUBREC;
      end
      res_o.retain_action = st_upd.flags[0] && (st_upd.payload_count != 28'd0);
    end
  end

  // the final byte returns the parser to idle
  assign st_d = end_of_packet_i ? '0 : st_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

### rtl/publish_packet_parser_top.sv
`default_nettype none

// Byte-serial parser for one MQTT PUBLISH packet at a time. Feed the packet
// in wire order, one transfer per byte, with end_of_packet_i high on the last
// byte; every byte gives exactly one result transfer that tags the byte
// (header, remaining-length digit, topic length, topic, packet id, payload,
// or ignored after a malformed length) and shows the fields gathered so far.
// The result on the last byte carries the final status, the ack to send
// (none, PUBACK, PUBREC) and the retained-message action, and the parser then
// waits for the next header byte. Throughput is one byte per clock unless the
// result side stalls: the whole per-byte state update is one pass through the
// parser core between the input register and the result register. A byte is
// taken into the input register, then moves through the core into the result
// register, raising result valid, once that register is free. Stall on the
// output side propagates to in_stall_o once both registers hold data.
module publish_packet_parser_top
  import ppp_pkg::*;
#(
  parameter int MAX_LEN_DIGITS = DEF_MAX_LEN_DIGITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_packet_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       byte_kind_o,
  output logic [7:0]       byte_value_o,
  output logic             packet_done_o,
  output logic [2:0]       status_o,
  output logic [1:0]       qos_level_o,
  output logic             dup_flag_o,
  output logic             retain_flag_o,
  output logic [15:0]      packet_ident_o,
  output logic [15:0]      topic_size_o,
  output logic [27:0]      payload_total_o,
  output logic [1:0]       ack_kind_o,
  output logic             retain_action_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eop_q;

  // result register
  logic       out_vld_q;
  result_t    res_q;
  result_t    core_res;

  logic out_ready;
  logic advance;
  logic in_xfer;

  // result register can take a new value when empty or being drained
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= data_byte_i;
      in_eop_q  <= end_of_packet_i;
    end
  end

  // state advances exactly once per byte, as the byte moves to the result reg
  ppp_core #(
    .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (in_byte_q),
    .end_of_packet_i (in_eop_q),
    .res_o           (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign byte_kind_o     = res_q.byte_kind;
  assign byte_value_o    = res_q.byte_value;
  assign packet_done_o   = res_q.packet_done;
  assign status_o        = res_q.status;
  assign qos_level_o     = res_q.qos_level;
  assign dup_flag_o      = res_q.dup_flag;
  assign retain_flag_o   = res_q.retain_flag;
  assign packet_ident_o  = res_q.packet_ident;
  assign topic_size_o    = res_q.topic_size;
  assign payload_total_o = res_q.payload_total;
  assign ack_kind_o      = res_q.ack_kind;
  assign retain_action_o = res_q.retain_action;

endmodule

`default_nettype wire

### rtl/ppp_checker.sv
`default_nettype none

`include "publish_packet_parser_top_defines.svh"

module ppp_checker
  import ppp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic [2:0]  byte_kind_o,
  input wire logic        packet_done_o,
  input wire logic [2:0]  status_o,
  input wire logic [1:0]  qos_level_o,
  input wire logic        retain_flag_o,
  input wire logic [15:0] packet_ident_o,
  input wire logic [15:0] topic_size_o,
  input wire logic [27:0] payload_total_o,
  input wire logic [1:0]  ack_kind_o,
  input wire logic        retain_action_o
);

  // an ack only closes a good packet
  `PPP_ASSERT(a_ack_only_ok,
    out_valid_o && (ack_kind_o != ACK_NONE) |-> packet_done_o && (status_o == ST_OK),
    "ack on unfinished or failed packet")

  // a good QoS 1 packet must be answered with PUBACK
  `PPP_ASSERT(a_qos1_puback,
    out_valid_o && packet_done_o && (status_o == ST_OK) && (qos_level_o == QOS_1)
      |-> ack_kind_o == ACK_PUBACK,
    "QoS 1 packet without PUBACK")

  // store only with RETAIN set and some payload
  `PPP_ASSERT(a_retain_store,
    out_valid_o && retain_action_o |-> retain_flag_o && (payload_total_o != 28'd0),
    "retain store without flag or payload")

  // a header byte starts from cleared fields
  `PPP_ASSERT(a_header_clears,
    out_valid_o && (byte_kind_o == KIND_HEADER) |-> (packet_ident_o == 16'd0)
      && (topic_size_o == 16'd0) && (payload_total_o == 28'd0),
    "header result with stale fields")

  // nothing comes out while reset is held
  `PPP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind publish_packet_parser_top ppp_checker u_ppp_checker (.*);

`default_nettype wire
